@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held low.
`define GCL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define GCL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/gcl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gcl_pkg;

    // Largest track count that a request may use on either axis.
    localparam int MAX_TRACKS = 256;

    // Field widths of registers, requests and results.
    localparam int ORG_W  = 16;
    localparam int EXT_W  = 15;
    localparam int CNT_W  = 9;
    localparam int GAP_W  = 10;
    localparam int IDX_W  = 8;
    localparam int SPAN_W = 9;
    localparam int END_W  = 10;
    localparam int OUT_W  = 18;

    // Internal arithmetic widths.
    localparam int GT_W    = 18;          // gap times index, also gap times (count - 1)
    localparam int INNER_W = 19;          // signed track extent without gaps
    localparam int MUL_W   = INNER_W + END_W + 1;
    localparam int PROD_W  = 28;          // signed inner times index
    localparam int MAG_W   = PROD_W - 1;  // magnitude of that product
    localparam int Q_W     = 18;          // quotient bits, one divider stage each
    localparam int SUM_W   = 21;          // signed edge and size before saturation

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Stream payloads.
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;

    // Request queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // Divider lanes: near and far edge on each axis.
    localparam int LANES   = 4;
    localparam int LANE_X0 = 0;
    localparam int LANE_X1 = 1;
    localparam int LANE_Y0 = 2;
    localparam int LANE_Y1 = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Y   = 3'd1,
        CFG_AREA_W     = 3'd2,
        CFG_AREA_H     = 3'd3,
        CFG_COL_COUNT  = 3'd4,
        CFG_ROW_COUNT  = 3'd5,
        CFG_COL_GAP    = 3'd6,
        CFG_ROW_GAP    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [ORG_W-1:0] origin_x;
        logic signed [ORG_W-1:0] origin_y;
        logic [EXT_W-1:0]        area_w;
        logic [EXT_W-1:0]        area_h;
        logic [CNT_W-1:0]        col_cnt;
        logic [CNT_W-1:0]        row_cnt;
        logic [GAP_W-1:0]        col_gap;
        logic [GAP_W-1:0]        row_gap;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        origin_x: '0,
        origin_y: '0,
        area_w:   '0,
        area_h:   '0,
        col_cnt:  CNT_W'(1),
        row_cnt:  CNT_W'(1),
        col_gap:  '0,
        row_gap:  '0
    };

    // One classified request as it waits in the queue.
    typedef struct packed {
        logic                           in_range;
        logic [LANES-1:0][PROD_W-1:0]   prod;
        logic [LANES-1:0][GT_W-1:0]     gterm;
    } t_job;

    // Count as the layout uses it: zero reads as one, large counts are capped.
    function automatic logic [CNT_W-1:0] clamp_count(logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0) begin
            r = CNT_W'(1);
        end else if (int'(c) > MAX_TRACKS) begin
            r = CNT_W'(MAX_TRACKS);
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/gcl_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcl_front import gcl_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [IDX_W-1:0]  i_col,
    input  wire logic [IDX_W-1:0]  i_row,
    input  wire logic [SPAN_W-1:0] i_col_span,
    input  wire logic [SPAN_W-1:0] i_row_span,
    input  wire logic              i_full,
    output logic                   o_push,
    output t_job                   o_job
);

    logic [SPAN_W-1:0]        col_span_e;
    logic [SPAN_W-1:0]        row_span_e;
    logic [END_W-1:0]         col_end;
    logic [END_W-1:0]         row_end;
    logic [CNT_W-1:0]         ncol;
    logic [CNT_W-1:0]         nrow;
    logic [GT_W-1:0]          col_gaps;
    logic [GT_W-1:0]          row_gaps;
    logic signed [INNER_W-1:0] inner_x;
    logic signed [INNER_W-1:0] inner_y;
    logic                     fits;
    logic                     accept;

    logic                     r_vld;
    logic                     r_in_range;
    logic [LANES-1:0][END_W-1:0] r_idx;
    logic signed [INNER_W-1:0] r_inner_x;
    logic signed [INNER_W-1:0] r_inner_y;

    logic signed [MUL_W-1:0]  mul_full [LANES];
    logic [2*END_W-1:0]       gap_full [LANES];

    assign o_ready = !r_vld || !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_vld && !i_full;

    // Classification: effective spans, far indexes, the grid fit test and the inner extents.
    always_comb begin
        col_span_e = (i_col_span == '0) ? SPAN_W'(1) : i_col_span;
        row_span_e = (i_row_span == '0) ? SPAN_W'(1) : i_row_span;
        col_end    = END_W'(i_col) + END_W'(col_span_e);
        row_end    = END_W'(i_row) + END_W'(row_span_e);
        ncol       = clamp_count(i_cfg.col_cnt);
        nrow       = clamp_count(i_cfg.row_cnt);
        fits       = (col_end <= END_W'(ncol)) && (row_end <= END_W'(nrow));
        col_gaps   = GT_W'(GT_W'(i_cfg.col_gap) * GT_W'(ncol - CNT_W'(1)));
        row_gaps   = GT_W'(GT_W'(i_cfg.row_gap) * GT_W'(nrow - CNT_W'(1)));
        inner_x    = $signed(INNER_W'(i_cfg.area_w)) - $signed(INNER_W'(col_gaps));
        inner_y    = $signed(INNER_W'(i_cfg.area_h)) - $signed(INNER_W'(row_gaps));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_range       <= fits;
            r_idx[LANE_X0]   <= END_W'(i_col);
            r_idx[LANE_X1]   <= col_end;
            r_idx[LANE_Y0]   <= END_W'(i_row);
            r_idx[LANE_Y1]   <= row_end;
            r_inner_x        <= inner_x;
            r_inner_y        <= inner_y;
        end
    end

    // Inner extent times track index, and gap times track index, per lane.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (l < LANE_Y0) begin
                mul_full[l] = r_inner_x * $signed({1'b0, r_idx[l]});
                gap_full[l] = END_W'(i_cfg.col_gap) * r_idx[l];
            end else begin
                mul_full[l] = r_inner_y * $signed({1'b0, r_idx[l]});
                gap_full[l] = END_W'(i_cfg.row_gap) * r_idx[l];
            end
            o_job.prod[l]  = mul_full[l][PROD_W-1:0];
            o_job.gterm[l] = gap_full[l][GT_W-1:0];
        end
        o_job.in_range = r_in_range;
    end

endmodule

`default_nettype wire

@@ rtl/gcl_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcl_queue import gcl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_job
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

@@ rtl/gcl_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcl_back import gcl_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_empty,
    output logic                   o_pop,
    input  wire t_job              i_job,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output logic [OUT_W-1:0]       o_x,
    output logic [OUT_W-1:0]       o_y,
    output logic [OUT_W-1:0]       o_w,
    output logic [OUT_W-1:0]       o_h,
    output logic                   o_in_range
);

    typedef struct packed {
        logic             sign;
        logic [MAG_W-1:0] rem;
        logic [Q_W-1:0]   quo;
    } t_lane;

    typedef struct packed {
        logic                       in_range;
        logic [LANES-1:0]           sign;
        t_lane [LANES-1:0]          lane;
        logic [LANES-1:0][GT_W-1:0] gterm;
    } t_stage;

    localparam logic signed [SUM_W-1:0] OUT_MAX_S = SUM_W'(2 ** (OUT_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] OUT_MIN_S = SUM_W'(-(2 ** (OUT_W - 1)));

    // One restoring step: try the divisor at quotient bit sh.
    function automatic t_lane div_step(t_lane l, logic [CNT_W-1:0] d, int sh);
        logic [MAG_W-1:0] dsh;
        t_lane            r;
        dsh = MAG_W'(d) << sh;
        r   = l;
        if (l.rem >= dsh) begin
            r.rem = l.rem - dsh;
            r.quo = l.quo | (Q_W'(1) << sh);
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        if (v > OUT_MAX_S) begin
            c = OUT_MAX_S;
        end else if (v < OUT_MIN_S) begin
            c = OUT_MIN_S;
        end else begin
            c = v;
        end
        return c[OUT_W-1:0];
    endfunction

    logic                     en;
    logic [CNT_W-1:0]         ncol;
    logic [CNT_W-1:0]         nrow;
    logic [PROD_W-1:0]        neg_prod [LANES];
    t_stage                   n_stg [Q_W+1];
    t_stage                   r_stg [Q_W+1];
    logic [Q_W:0]             r_vld;
    logic                     r_out_vld;

    logic signed [INNER_W-1:0] qs [LANES];
    logic signed [SUM_W-1:0]  x0;
    logic signed [SUM_W-1:0]  y0;
    logic signed [SUM_W-1:0]  w;
    logic signed [SUM_W-1:0]  h;

    // The whole back pipeline moves as one while the output can take a beat.
    assign en      = !r_out_vld || i_ready;
    assign o_pop   = en && !i_empty;
    assign o_valid = r_out_vld;
    assign ncol    = clamp_count(i_cfg.col_cnt);
    assign nrow    = clamp_count(i_cfg.row_cnt);

    always_comb begin
        n_stg[0].in_range = i_job.in_range;
        n_stg[0].gterm    = i_job.gterm;
        for (int l = 0; l < LANES; l++) begin
            neg_prod[l]           = -i_job.prod[l];
            n_stg[0].sign[l]      = i_job.prod[l][PROD_W-1];
            n_stg[0].lane[l].sign = i_job.prod[l][PROD_W-1];
            n_stg[0].lane[l].rem  = i_job.prod[l][PROD_W-1] ? neg_prod[l][MAG_W-1:0]
                                                            : i_job.prod[l][MAG_W-1:0];
            n_stg[0].lane[l].quo  = '0;
        end
        // Each stage works on its own registered operand: quotient bit MSB first.
        for (int s = 0; s < Q_W; s++) begin
            n_stg[s+1].in_range = r_stg[s].in_range;
            n_stg[s+1].gterm    = r_stg[s].gterm;
            n_stg[s+1].sign     = r_stg[s].sign;
            for (int l = 0; l < LANES; l++) begin
                n_stg[s+1].lane[l] = div_step(r_stg[s].lane[l],
                                              (l < LANE_Y0) ? ncol : nrow, Q_W - 1 - s);
            end
        end
    end

    // Signed quotients, then edges and sizes. The origin drops out of the sizes.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            qs[l] = r_stg[Q_W].sign[l] ? -$signed({1'b0, r_stg[Q_W].lane[l].quo})
                                       :  $signed({1'b0, r_stg[Q_W].lane[l].quo});
        end
        x0 = SUM_W'(i_cfg.origin_x) + SUM_W'(qs[LANE_X0])
           + SUM_W'(r_stg[Q_W].gterm[LANE_X0]);
        y0 = SUM_W'(i_cfg.origin_y) + SUM_W'(qs[LANE_Y0])
           + SUM_W'(r_stg[Q_W].gterm[LANE_Y0]);
        w  = SUM_W'(qs[LANE_X1]) - SUM_W'(qs[LANE_X0])
           + SUM_W'(r_stg[Q_W].gterm[LANE_X1]) - SUM_W'(r_stg[Q_W].gterm[LANE_X0])
           - SUM_W'(i_cfg.col_gap);
        h  = SUM_W'(qs[LANE_Y1]) - SUM_W'(qs[LANE_Y0])
           + SUM_W'(r_stg[Q_W].gterm[LANE_Y1]) - SUM_W'(r_stg[Q_W].gterm[LANE_Y0])
           - SUM_W'(i_cfg.row_gap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[Q_W-1:0], !i_empty};
            r_out_vld <= r_vld[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_stg      <= n_stg;
            o_in_range <= r_stg[Q_W].in_range;
            if (r_stg[Q_W].in_range) begin
                o_x <= sat_out(x0);
                o_y <= sat_out(y0);
                o_w <= sat_out(w);
                o_h <= sat_out(h);
            end else begin
                o_x <= '0;
                o_y <= '0;
                o_w <= '0;
                o_h <= '0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/grid_cell_layout_unit.sv @@
// Grid cell layout: for a request naming a first column and row and a span on
// each axis, the block returns the pixel rectangle of that cell in a grid whose
// bounds, track counts and gaps sit in eight write-only registers. Each track
// edge is origin + (inner * index) / count + gap * index with the division
// truncated toward zero, and a request that runs off the grid returns an
// all-zero rectangle with the in_range flag in tuser cleared. The block takes
// one request beat per clock cycle and keeps that rate as long as the output
// side takes results. The back end holds a pipelined restoring divider that
// settles one quotient bit per stage over 18 stages, running four lanes
// (near and far edge on both axes) side by side. A front stage classifies
// each request and forms the products, and a four-entry queue lets the front
// keep taking requests for a while when the output stalls. There is no
// clearing pass after reset. Registers should be written only while no
// request is in flight; a write takes effect at the next clock edge.
`timescale 1ns / 1ps
`default_nettype none

module grid_cell_layout_unit import gcl_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Configuration write port.
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    // Request stream.
    input  wire logic                    i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // From bit 0: cell_column[7:0], cell_row[15:8], column_span[24:16],
    // row_span[33:25], zero fill[39:34].
    input  wire logic [IN_TDATA_W-1:0]   i_s_axis_tdata,
    // Result stream.
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    // From bit 0: cell_x[17:0], cell_y[35:18], cell_w[53:36], cell_h[71:54].
    output logic [OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // Bit 0: in_range.
    output logic                         o_m_axis_tuser
);

    t_cfg              r_cfg;
    t_job              front_job;
    t_job              queue_job;
    logic              push;
    logic              full;
    logic              pop;
    logic              empty;
    logic [OUT_W-1:0]  res_x;
    logic [OUT_W-1:0]  res_y;
    logic [OUT_W-1:0]  res_w;
    logic [OUT_W-1:0]  res_h;

    // Register writes. Every index of the port names a register, and each
    // takes the low bits of the write data that its width calls for.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X:  r_cfg.origin_x <= $signed(i_cfg_data[ORG_W-1:0]);
                CFG_ORIGIN_Y:  r_cfg.origin_y <= $signed(i_cfg_data[ORG_W-1:0]);
                CFG_AREA_W:    r_cfg.area_w   <= i_cfg_data[EXT_W-1:0];
                CFG_AREA_H:    r_cfg.area_h   <= i_cfg_data[EXT_W-1:0];
                CFG_COL_COUNT: r_cfg.col_cnt  <= i_cfg_data[CNT_W-1:0];
                CFG_ROW_COUNT: r_cfg.row_cnt  <= i_cfg_data[CNT_W-1:0];
                CFG_COL_GAP:   r_cfg.col_gap  <= i_cfg_data[GAP_W-1:0];
                CFG_ROW_GAP:   r_cfg.row_gap  <= i_cfg_data[GAP_W-1:0];
            endcase
        end
    end

    // Front end: takes request beats, checks them against the grid and forms
    // the inner-extent and gap products for both edges on both axes.
    gcl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_col      (i_s_axis_tdata[7:0]),
        .i_row      (i_s_axis_tdata[15:8]),
        .i_col_span (i_s_axis_tdata[24:16]),
        .i_row_span (i_s_axis_tdata[33:25]),
        .i_full     (full),
        .o_push     (push),
        .o_job      (front_job)
    );

    // Short queue that decouples the front end from output stalls.
    gcl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (queue_job)
    );

    // Back end: divides by the track counts and builds the rectangle.
    gcl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (empty),
        .o_pop      (pop),
        .i_job      (queue_job),
        .i_ready    (i_m_axis_tready),
        .o_valid    (o_m_axis_tvalid),
        .o_x        (res_x),
        .o_y        (res_y),
        .o_w        (res_w),
        .o_h        (res_h),
        .o_in_range (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {res_h, res_w, res_y, res_x};

endmodule

`default_nettype wire

@@ rtl/gcl_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gcl_checker import gcl_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_s_axis_tready,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                   o_m_axis_tuser
);

    // Reset empties the pipeline: no result beat right after it.
    `GCL_ASSERT_ALWAYS(a_rst_no_result, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result after reset")

    // Reset leaves the front stage free, so a request can be taken at once.
    `GCL_ASSERT_ALWAYS(a_rst_ready, i_clk, !i_rst_n |=> o_s_axis_tready, "not ready after reset")

    // A rejected request always comes back as an all-zero rectangle.
    `GCL_ASSERT(a_reject_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0, "rejected request with nonzero rectangle")

    // A stalled result beat holds until it is taken.
    `GCL_ASSERT(a_hold_stall, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")

endmodule

bind grid_cell_layout_unit gcl_checker u_gcl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

@@ test/tb_grid_cell_layout_unit.sv @@
`timescale 1ns / 1ps

module tb_grid_cell_layout_unit;
    import gcl_pkg::*;

    // A request beat as it sits in s_axis tdata. The first member of a packed
    // struct lands in the top bits, so the column comes last.
    typedef struct packed {
        logic [SPAN_W-1:0] row_span;
        logic [SPAN_W-1:0] col_span;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
    } t_cell_req;

    // A result beat: tuser on top of the four tdata fields. This lets a
    // received beat be unpacked with a single concatenation.
    typedef struct packed {
        logic              in_range;
        logic [OUT_W-1:0]  h;
        logic [OUT_W-1:0]  w;
        logic [OUT_W-1:0]  y;
        logic [OUT_W-1:0]  x;
    } t_cell_rect;

    // The scoreboard keeps its own copy of the eight grid registers. From each
    // accepted request it works out the rectangle that the block should
    // return, and it queues that rectangle until the matching result beat
    // shows up.
    class t_cell_rect_scoreboard;
        logic signed [ORG_W-1:0] org_x, org_y;
        logic [EXT_W-1:0]        ext_w, ext_h;
        logic [CNT_W-1:0]        cols, rows;
        logic [GAP_W-1:0]        gap_x, gap_y;
        t_cell_rect              pending_rects[$];
        int                      errors;

        function new();
            org_x = '0;
            org_y = '0;
            ext_w = '0;
            ext_h = '0;
            cols = CNT_W'(1);
            rows = CNT_W'(1);
            gap_x = '0;
            gap_y = '0;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_ORIGIN_X:  org_x = v;
                CFG_ORIGIN_Y:  org_y = v;
                CFG_AREA_W:    ext_w = v[EXT_W-1:0];
                CFG_AREA_H:    ext_h = v[EXT_W-1:0];
                CFG_COL_COUNT: cols = v[CNT_W-1:0];
                CFG_ROW_COUNT: rows = v[CNT_W-1:0];
                CFG_COL_GAP:   gap_x = v[GAP_W-1:0];
                CFG_ROW_GAP:   gap_y = v[GAP_W-1:0];
                default: ;
            endcase
        endfunction

        // Track count as the layout sees it: zero reads as one, and anything
        // past the track limit is capped.
        function int tracks(logic [CNT_W-1:0] c);
            if (c == '0) return 1;
            if (int'(c) > MAX_TRACKS) return MAX_TRACKS;
            return int'(c);
        endfunction

        // Near edge of track number index. The inner extent goes negative
        // when the gaps add up to more than the box; SystemVerilog division
        // truncates toward zero, just as the block must.
        function longint track_edge(longint base, longint extent, longint gap,
                                    longint count, longint index);
            longint inner;
            inner = extent - gap * (count - 1);
            return base + (inner * index) / count + gap * index;
        endfunction

        function logic [OUT_W-1:0] sat18(longint v);
            if (v > 131071) return 18'h1FFFF;
            if (v < -131072) return 18'h20000;
            return v[OUT_W-1:0];
        endfunction

        function void note_request(t_cell_req r);
            longint ncol, nrow, cs, rs, x0, y0, x1, y1;
            t_cell_rect rect;
            ncol = tracks(cols);
            nrow = tracks(rows);
            cs = (r.col_span == '0) ? 1 : longint'(r.col_span);
            rs = (r.row_span == '0) ? 1 : longint'(r.row_span);
            rect = '0;
            if (longint'(r.col) + cs <= ncol && longint'(r.row) + rs <= nrow) begin
                x0 = track_edge(org_x, ext_w, gap_x, ncol, r.col);
                y0 = track_edge(org_y, ext_h, gap_y, nrow, r.row);
                x1 = track_edge(org_x, ext_w, gap_x, ncol, r.col + cs) - gap_x;
                y1 = track_edge(org_y, ext_h, gap_y, nrow, r.row + rs) - gap_y;
                rect.x = sat18(x0);
                rect.y = sat18(y0);
                rect.w = sat18(x1 - x0);
                rect.h = sat18(y1 - y0);
                rect.in_range = 1'b1;
            end
            pending_rects.push_back(rect);
        endfunction

        function void compare_field(string field, logic signed [OUT_W-1:0] want,
                                    logic signed [OUT_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_rect(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
            t_cell_rect want, got;
            got = {tuser, tdata};
            if (pending_rects.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected, expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_rects.pop_front();
            compare_field("cell_x", want.x, got.x);
            compare_field("cell_y", want.y, got.y);
            compare_field("cell_w", want.w, got.w);
            compare_field("cell_h", want.h, got.h);
            compare_field("in_range", OUT_W'(want.in_range), OUT_W'(got.in_range));
        endfunction

        function int pending();
            return pending_rects.size();
        endfunction
    endclass

    // Cycles without any accepted beat before the run is declared hung. The
    // slowest correct gap is the pipeline latency plus a stall run on the
    // output side plus a register update, far below this.
    localparam int STALL_LIMIT = 4000;
    // Settle time at the end, a little over the pipeline latency.
    localparam int DRAIN_CYCLES = 30;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    // From bit 0: cell_column, cell_row, column_span, row_span, zero fill.
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    // From bit 0: cell_x, cell_y, cell_w, cell_h.
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    // Bit 0: in_range.
    logic                    o_m_axis_tuser;

    t_cell_rect_scoreboard sb;
    int tx_idle_pct = 32;
    int rx_idle_pct = 49;
    int quiet_cycles = 0;

    grid_cell_layout_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Output side: tready is redrawn at every falling edge, so stalls land on
    // every phase of the pipeline. A zero percentage gives a clean stretch.
    initial begin
        forever begin
            @(negedge i_clk);
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // All beats are observed at the rising edge, where the handshake counts.
    // A request beat feeds the predictor and a result beat gets checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.note_request(t_cell_req'(i_s_axis_tdata[$bits(t_cell_req)-1:0]));
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_rect(o_m_axis_tdata, o_m_axis_tuser);
            end
        end
    end

    // Hang detector: counts cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Every driving task starts and ends just after a falling edge.

    // One request beat. The sender may idle first; tvalid then stays high
    // until the block takes the beat.
    task automatic send_cell(input int col, input int row, input int cspan, input int rspan);
        t_cell_req r;
        r.col = IDX_W'(col);
        r.row = IDX_W'(row);
        r.col_span = SPAN_W'(cspan);
        r.row_span = SPAN_W'(rspan);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= IN_TDATA_W'(r);
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every queued rectangle has come back. Since
    // each request yields exactly one result, the pipeline is empty then.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
        @(negedge i_clk);
    endtask

    // Writes all eight registers back to back; the enable stays high over the
    // whole burst and drops after it.
    task automatic write_grid(input logic [15:0] ox, input logic [15:0] oy,
                              input logic [14:0] aw, input logic [14:0] ah,
                              input logic [8:0] nc, input logic [8:0] nr,
                              input logic [9:0] gx, input logic [9:0] gy);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_AREA_W, CFG_DATA_W'(aw));
        write_reg(CFG_AREA_H, CFG_DATA_W'(ah));
        write_reg(CFG_COL_COUNT, CFG_DATA_W'(nc));
        write_reg(CFG_ROW_COUNT, CFG_DATA_W'(nr));
        write_reg(CFG_COL_GAP, CFG_DATA_W'(gx));
        write_reg(CFG_ROW_GAP, CFG_DATA_W'(gy));
        i_cfg_we <= 1'b0;
    endtask

    // One idling regime with two random grids. Requests are mostly well formed
    // (they fit the grid, with random position and span); the rest are raw
    // random fields or requests that overrun the grid by exactly one track.
    task automatic run_phase(input int tx_pct, input int rx_pct);
        logic [15:0] org [2];
        logic [14:0] ext [2];
        logic [8:0]  cnt [2];
        logic [9:0]  gap [2];
        int ncol, nrow, col, row, cspan, rspan;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int blk = 0; blk < 2; blk++) begin
            wait_idle();
            for (int a = 0; a < 2; a++) begin
                org[a] = 16'($urandom);
                case ($urandom_range(5))
                    0: ext[a] = '0;
                    1: ext[a] = 15'h7FFF;
                    default: ext[a] = 15'($urandom_range(32767));
                endcase
                // Small counts dominate so that most requests land inside,
                // but zero and over-limit counts come up as well.
                case ($urandom_range(9))
                    0: cnt[a] = '0;
                    1: cnt[a] = 9'($urandom_range(257, 511));
                    2: cnt[a] = 9'($urandom_range(1, 256));
                    3: cnt[a] = 9'd256;
                    default: cnt[a] = 9'($urandom_range(1, 12));
                endcase
                case ($urandom_range(4))
                    0: gap[a] = '0;
                    1: gap[a] = 10'd1023;
                    2: gap[a] = 10'($urandom_range(1023));
                    default: gap[a] = 10'($urandom_range(40));
                endcase
            end
            write_grid(org[0], org[1], ext[0], ext[1], cnt[0], cnt[1], gap[0], gap[1]);
            ncol = sb.tracks(cnt[0]);
            nrow = sb.tracks(cnt[1]);
            for (int n = 0; n < 165; n++) begin
                // Halfway through the first grid of each phase the sender
                // holds off until the pipeline has drained completely.
                if (blk == 0 && n == 80) begin
                    wait_idle();
                end
                col = $urandom_range(ncol - 1);
                row = $urandom_range(nrow - 1);
                cspan = $urandom_range(ncol - col);
                rspan = $urandom_range(nrow - row);
                if ($urandom_range(99) >= 85) begin
                    case ($urandom_range(2))
                        0: begin
                            col = $urandom_range(255);
                            row = $urandom_range(255);
                            cspan = $urandom_range(511);
                            rspan = $urandom_range(511);
                        end
                        1: cspan = ncol - col + 1;
                        default: rspan = nrow - row + 1;
                    endcase
                end
                send_cell(col, row, cspan, rspan);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset grid: a single track of zero size on both axes. Only the
        // origin cell fits, with or without a zero span.
        send_cell(0, 0, 0, 0);
        send_cell(0, 0, 1, 1);
        send_cell(1, 0, 0, 0);
        send_cell(0, 1, 1, 1);

        // Extreme registers: the gaps far exceed the box, so the inner extent
        // is negative and the division has to truncate toward zero.
        wait_idle();
        write_grid(16'h8000, 16'h7FFF, 15'h7FFF, 15'h7FFF, 9'd256, 9'd256, 10'd1023, 10'd1023);
        send_cell(0, 0, 256, 256);
        send_cell(255, 255, 0, 0);
        send_cell(255, 255, 2, 1);
        send_cell(0, 0, 257, 1);
        send_cell(128, 64, 100, 50);
        send_cell(255, 0, 1, 511);
        send_cell(0, 255, 511, 1);

        // A zero column count reads as one and a row count of 511 is capped
        // at the track limit.
        wait_idle();
        write_grid(16'h7FFF, 16'h8000, 15'd0, 15'd1, 9'd0, 9'd511, 10'd0, 10'd1);
        send_cell(0, 0, 0, 0);
        send_cell(1, 0, 1, 1);
        send_cell(0, 255, 1, 1);
        send_cell(0, 255, 1, 2);
        send_cell(0, 0, 1, 256);
        send_cell(0, 128, 0, 0);

        // Counts just above the limit with a plain, uneven grid.
        wait_idle();
        write_grid(16'd100, -16'sd50, 15'd1000, 15'd777, 9'd300, 9'd257, 10'd3, 10'd5);
        send_cell(17, 33, 5, 9);
        send_cell(0, 0, 256, 256);
        send_cell(255, 255, 1, 1);

        // Random traffic under three idling regimes: both sides busy, the
        // same with the roles swapped, and no idling at all.
        run_phase(32, 49);
        run_phase(49, 32);
        run_phase(0, 0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
